// File: hdl/deq_pkg.sv
// deq_pkg: shared sizes, request and status codes, and the cell command struct
// for the double-ended queue. Depends on nothing; used by deq_cell and
// double_ended_queue.
package deq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Port field widths, fixed by the interface
  localparam int unsigned REQ_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 2;
  localparam int unsigned OCC_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic                  shift_up;    // push front: everything moves one cell back
    logic                  shift_down;  // pop front: everything moves one cell forward
    logic                  push_back;   // first free cell takes the value
    logic                  pop_back;    // last occupied cell empties
    logic [DATA_WIDTH-1:0] value;
  } deq_cmd_t;

endpackage

// File: hdl/deq_cell.sv
// deq_cell: one storage position of the queue row, holding a value and an
// occupied flag. Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deq_cmd_t              cmd_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,   // neighbour nearer the front
  input  logic                  left_occ_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,  // neighbour nearer the back
  input  logic                  right_occ_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  occ_o,
  output logic                  tail_o         // this cell holds the back entry
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  occ_q, occ_d;

  assign tail_o = occ_q & ~right_occ_i;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (cmd_i.shift_up) begin
      data_d = left_data_i;
      occ_d  = left_occ_i;
    end else if (cmd_i.shift_down) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end else if (cmd_i.push_back && !occ_q && left_occ_i) begin
      data_d = cmd_i.value;
      occ_d  = 1'b1;
    end else if (cmd_i.pop_back && tail_o) begin
      occ_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;

endmodule

// File: hdl/double_ended_queue.sv
// double_ended_queue: top level of the deque, a row of deq_cell instances
// with the request decoder, fill counter and output register.
// Depends on deq_pkg and deq_cell.
//
//   channel | handshake            | fields                            | dir
//   --------+----------------------+-----------------------------------+----
//   request | in_valid_i/in_stall_o| req_type_i, push_value_i          | in
//   result  | out_valid_o/out_stall_i| pop_value_o, status_o, occupancy_o| out
//
// One request per cycle unless stalled: a transaction is decoded and applied
// to the whole cell row in the cycle it is accepted, and its result sits in the
// output register from the next cycle on. The front entry always lives in cell 0;
// the back entry is the last occupied cell, picked by a one-hot AND-OR mux.
// Reset clears the occupied flags and the counter; no clearing pass is needed.
// in_stall_o is raised only while a result is held and the sink stalls.
module double_ended_queue import deq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic signed [VAL_W-1:0] push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] pop_value_o,
  output logic [STS_W-1:0]        status_o,
  output logic [OCC_W-1:0]        occupancy_o
);

  // ---------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------
  deq_cmd_t              cmd;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_occ;
  logic [DEPTH-1:0]      cell_tail;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;
    logic                  left_occ, right_occ;

    if (i == 0) begin : g_first
      assign left_data = cmd.value;   // push front enters here
      assign left_occ  = 1'b1;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cmd.value;  // never kept: right_occ is low
      assign right_occ  = 1'b0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    deq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_data_i (left_data),
      .left_occ_i  (left_occ),
      .right_data_i(right_data),
      .right_occ_i (right_occ),
      .data_o      (cell_data[i]),
      .occ_o       (cell_occ[i]),
      .tail_o      (cell_tail[i])
    );
  end

  // Back entry: at most one tail flag is set
  logic [DATA_WIDTH-1:0] tail_data;
  always_comb begin
    tail_data = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      tail_data = tail_data | (cell_data[k] & {DATA_WIDTH{cell_tail[k]}});
    end
  end

  // ---------------------------------------------------------------------
  // Decode and fill count
  // ---------------------------------------------------------------------
  logic             accept;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;
  req_e             req;

  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] pop_value_q, pop_value_d;
  status_e                 status_q, status_d;
  logic [CNT_W-1:0]        occ_q, occ_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign req        = req_e'(req_type_i);

  always_comb begin
    cmd         = '0;
    cmd.value   = DATA_WIDTH'(push_value_i);
    count_d     = count_q;
    pop_value_d = '0;
    status_d    = STS_OK;

    unique case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          status_d = STS_FULL;
        end else begin
          cmd.shift_up  = accept & (req == REQ_PUSH_FRONT);
          cmd.push_back = accept & (req == REQ_PUSH_BACK);
          count_d       = count_q + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          cmd.shift_down = accept;
          pop_value_d    = VAL_W'($signed(cell_data[0]));
          count_d        = count_q - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          cmd.pop_back = accept;
          pop_value_d  = VAL_W'($signed(tail_data));
          count_d      = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = STS_OK;
      end
    endcase

    occ_d       = count_d;
    out_valid_d = accept | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      occ_q       <= occ_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_value_q;
  assign status_o    = status_q;
  assign occupancy_o = OCC_W'(occ_q);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_occ) == 32'(count_q))
    else $error("fill count disagrees with occupied cells");

  a_single_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_tail))
    else $error("more than one back entry in the row");

  a_row_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> cell_occ[0])
    else $error("queue not empty but cell 0 is free");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && empty && (req == REQ_POP_FRONT || req == REQ_POP_BACK))
    |=> (status_q == STS_EMPTY && count_q == $past(count_q) && pop_value_q == '0))
    else $error("pop on empty queue changed state or gave a value");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no result held");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for double_ended_queue, a directed table then random
// fill, drain and mixed phases, checked against hand-typed results or an in-bench mirror.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_top import deq_pkg::*; ();

  // Shape of the run
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned IDLE_PCT     = 15;
  localparam int unsigned DRAIN_CYCLES = 8;    // result register is one deep; a few spare
  localparam int unsigned DIR_ROWS     = 18;

  typedef struct packed {
    logic [VAL_W-1:0] pop_value;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  typedef struct {
    req_e             req;
    logic [VAL_W-1:0] value;
    bit               hand_typed;  // 1: expected result below is used as is
    result_t          want;
  } dir_row_t;

  // Random traffic phases: bias towards pushes, towards pops, or neither
  typedef enum int unsigned {PH_FILL = 0, PH_DRAIN = 1, PH_MIX = 2} phase_e;

  logic                    clk_i;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [REQ_W-1:0]        req_type_i   = REQ_PUSH_FRONT;
  logic signed [VAL_W-1:0] push_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic signed [VAL_W-1:0] pop_value_o;
  logic [STS_W-1:0]        status_o;
  logic [OCC_W-1:0]        occupancy_o;

  // Mirror of the deque contents and pointers
  logic [DATA_WIDTH-1:0] mirror_store [DEPTH];
  int unsigned           mirror_front = 0;
  int unsigned           mirror_back  = 0;
  int unsigned           mirror_count = 0;

  result_t owed_results [$];

  bit          quiet_stretch = 1'b0;  // no idling on either side while set
  int unsigned mismatches    = 0;
  int unsigned compared      = 0;
  int unsigned pushes_done   = 0;
  int unsigned pops_done     = 0;
  int unsigned empty_pops    = 0;
  int unsigned refused_pushes = 0;
  int unsigned peak_fill     = 0;

  // Directed table: extremes, both ends, empty at reset and after draining.
  // Rows with hand_typed clear take their expectation from the mirror.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, STS_EMPTY, 7'd0}},
    '{REQ_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STS_EMPTY, 7'd0}},
    '{REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, STS_OK,    7'd1}},
    '{REQ_PUSH_BACK,  32'h8000_0000, 1'b1, '{32'h0000_0000, STS_OK,    7'd2}},
    '{REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STS_OK,    7'd3}},
    '{REQ_PUSH_BACK,  32'h0000_0000, 1'b1, '{32'h0000_0000, STS_OK,    7'd4}},
    '{REQ_POP_BACK,   32'h1234_5678, 1'b1, '{32'h0000_0000, STS_OK,    7'd3}},
    '{REQ_POP_BACK,   32'h0000_0000, 1'b1, '{32'h8000_0000, STS_OK,    7'd2}},
    '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, STS_OK,    7'd1}},
    '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STS_OK,    7'd0}},
    '{REQ_POP_FRONT,  32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, STS_EMPTY, 7'd0}},
    '{REQ_PUSH_BACK,  32'h5555_5555, 1'b0, '{32'h0000_0000, STS_OK,    7'd0}},
    '{REQ_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '{32'h0000_0000, STS_OK,    7'd0}},
    '{REQ_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0000_0000, STS_OK,    7'd0}},
    '{REQ_PUSH_FRONT, 32'h1234_5678, 1'b0, '{32'h0000_0000, STS_OK,    7'd0}},
    '{REQ_POP_BACK,   32'h0000_0000, 1'b0, '{32'h0000_0000, STS_OK,    7'd0}},
    '{REQ_POP_BACK,   32'h0000_0000, 1'b0, '{32'h0000_0000, STS_OK,    7'd0}},
    '{REQ_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0000_0000, STS_EMPTY, 7'd0}}
  };

  double_ended_queue i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  // 2 ns period, first rising edge at 1 ns
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Applies one request to the mirror and returns the result the block owes for it.
  // Full push and empty pop leave the mirror untouched.
  function automatic result_t mirror_apply(input req_e req, input logic [VAL_W-1:0] value);
    result_t                      res;
    logic signed [DATA_WIDTH-1:0] taken;
    res   = '{pop_value: '0, status: STS_OK, occupancy: '0};
    taken = '0;
    if (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) begin
      if (mirror_count >= DEPTH) begin
        res.status = STS_FULL;
        refused_pushes++;
      end else begin
        if (req == REQ_PUSH_FRONT) begin
          mirror_front = (mirror_front == 0) ? DEPTH - 1 : mirror_front - 1;
          mirror_store[mirror_front] = DATA_WIDTH'(value);
        end else begin
          mirror_store[mirror_back] = DATA_WIDTH'(value);
          mirror_back = (mirror_back + 1 >= DEPTH) ? 0 : mirror_back + 1;
        end
        mirror_count++;
        pushes_done++;
      end
    end else begin
      if (mirror_count == 0) begin
        res.status = STS_EMPTY;
        empty_pops++;
      end else begin
        if (req == REQ_POP_FRONT) begin
          taken = mirror_store[mirror_front];
          mirror_front = (mirror_front + 1 >= DEPTH) ? 0 : mirror_front + 1;
        end else begin
          mirror_back = (mirror_back == 0) ? DEPTH - 1 : mirror_back - 1;
          taken = mirror_store[mirror_back];
        end
        mirror_count--;
        pops_done++;
      end
    end
    if (mirror_count > peak_fill) peak_fill = mirror_count;
    res.pop_value = VAL_W'(taken);  // sign-extends from DATA_WIDTH
    res.occupancy = OCC_W'(mirror_count);
    return res;
  endfunction

  // Drives one request transaction, with a random idle gap first, and books its result
  // once accepted. Valid stays high into the next call unless that call idles.
  task automatic send_request(input req_e req, input logic [VAL_W-1:0] value,
                              input bit hand_typed, input result_t hand_result);
    result_t predicted;
    while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge; result cannot appear before the next one
    predicted = mirror_apply(req, value);
    owed_results.push_back(hand_typed ? hand_result : predicted);
  endtask

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
  end

  // Result checker: every accepted result against the oldest owed one
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      compared++;
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none owed: pop_value %h status %0d occupancy %0d",
                 $time, pop_value_o, status_o, occupancy_o);
      end else begin
        want = owed_results.pop_front();
        if (pop_value_o !== want.pop_value || status_o !== want.status ||
            occupancy_o !== want.occupancy) begin
          mismatches++;
          $display("%0t: mismatch: expected %h %0d %0d, got %h %0d %0d",
                   $time, want.pop_value, want.status, want.occupancy,
                   pop_value_o, status_o, occupancy_o);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    req_e        req;
    phase_e      phase;
    int unsigned phase_left;
    int unsigned roll;
    bit          is_push;
    bit          at_back;

    phase      = PH_FILL;
    phase_left = $urandom_range(100, 200);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      send_request(directed_rows[r].req, directed_rows[r].value,
                   directed_rows[r].hand_typed, directed_rows[r].want);

    // Random part: fill phases hammer the full store, drain phases the empty one
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = phase_e'((phase + 1) % 3);
        phase_left = $urandom_range(80, 200);
      end
      phase_left--;

      quiet_stretch = (n >= 600 && n < 900);

      // hold off once until every owed result is back
      if (n == 1200) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (owed_results.size() != 0);
      end

      roll = $urandom_range(99);
      case (phase)
        PH_FILL:  is_push = (roll < 90);
        PH_DRAIN: is_push = (roll < 10);
        default:  is_push = (roll < 50);
      endcase
      at_back = $urandom_range(1);
      if (is_push) req = at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else         req = at_back ? REQ_POP_BACK  : REQ_POP_FRONT;
      send_request(req, $urandom(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d pushes, %0d pops, %0d empty pops, %0d refused",
             DIR_ROWS + RANDOM_ITEMS, pushes_done, pops_done, empty_pops, refused_pushes);
    $display("Peak fill %0d of %0d; %0d results compared, %0d mismatches",
             peak_fill, DEPTH, compared, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
